// ===== rtl/core/sqoe_pkg.sv =====
// Package: opcode and status codes and the result bundle of the stack/queue engine.
`timescale 1ns / 1ps
package sqoe_pkg;

    localparam int KIND_W     = 3;
    localparam int STAT_W     = 3;
    localparam int OUT_W      = 32;
    localparam int MAX_RESULTS = 32;

    localparam logic [KIND_W-1:0] OP_PUSH = 3'd0;
    localparam logic [KIND_W-1:0] OP_PALL = 3'd1;
    localparam logic [KIND_W-1:0] OP_PINT = 3'd2;
    localparam logic [KIND_W-1:0] OP_POP  = 3'd3;
    localparam logic [KIND_W-1:0] OP_SWAP = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
    localparam logic [STAT_W-1:0] ST_BAD_ARG   = 3'd1;
    localparam logic [STAT_W-1:0] ST_PINT_EMPTY = 3'd2;
    localparam logic [STAT_W-1:0] ST_POP_EMPTY = 3'd3;
    localparam logic [STAT_W-1:0] ST_SWAP_SHORT = 3'd4;
    localparam logic [STAT_W-1:0] ST_FULL      = 3'd5;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [OUT_W-1:0]  data;
        logic              last;
    } t_res;

endpackage

// ===== rtl/core/sqoe_ram.sv =====
// Ring storage: one write port, one read port, registered read data.
`timescale 1ns / 1ps
module sqoe_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/sqoe_obuf.sv =====
// Output register slice for result requests.
`timescale 1ns / 1ps
module sqoe_obuf import sqoe_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  t_res                i_res,
    output logic                o_space,
    output logic                o_valid,
    input  logic                i_ready,
    output t_res                o_res
);

    logic r_valid;
    logic n_valid;
    t_res r_res;

    assign o_space = !r_valid || i_ready;

    always_comb begin
        n_valid = r_valid;
        if (i_push) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (i_push) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

// ===== rtl/core/sqoe_ctrl.sv =====
// Opcode sequencer: decodes requests, keeps head/count, drives the ring storage.
`timescale 1ns / 1ps
module sqoe_ctrl import sqoe_pkg::*; #(
    parameter int DEPTH      = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_wr_en,
    input  logic                     i_cfg_wr_data,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [KIND_W-1:0]        i_kind,
    input  logic [31:0]              i_value,
    input  logic                     i_value_ok,
    output logic                     o_mem_we,
    output logic [$clog2(DEPTH)-1:0] o_mem_waddr,
    output logic [VALUE_BITS-1:0]    o_mem_wdata,
    output logic                     o_mem_re,
    output logic [$clog2(DEPTH)-1:0] o_mem_raddr,
    input  logic [VALUE_BITS-1:0]    i_mem_rdata,
    input  logic                     i_space,
    output logic                     o_push,
    output t_res                     o_res
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;
    localparam int WW = 16;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DATA = 3'd1;
    localparam logic [2:0] S_EMIT = 3'd2;
    localparam logic [2:0] S_SW1  = 3'd3;
    localparam logic [2:0] S_SW2  = 3'd4;
    localparam logic [2:0] S_SW3  = 3'd5;

    logic [2:0]            r_state, n_state;
    logic [AW-1:0]         r_head, n_head;
    logic [CW-1:0]         r_count, n_count;
    logic                  r_qmode;
    logic [AW-1:0]         r_rptr, n_rptr;
    logic [CW-1:0]         r_left, n_left;
    logic [STAT_W-1:0]     r_err, n_err;
    logic [VALUE_BITS-1:0] r_tmp, n_tmp;

    logic                  accept;
    logic [AW-1:0]         head_inc, head_dec, rptr_inc, tail;
    logic [SW-1:0]         tail_sum;
    logic [CW-1:0]         cap;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign head_inc = wrap_inc(r_head);
    assign rptr_inc = wrap_inc(r_rptr);
    assign head_dec = (r_head == '0) ? AW'(DEPTH - 1) : r_head - 1'b1;
    assign tail_sum = SW'(r_head) + SW'(r_count);
    assign tail     = (tail_sum >= SW'(DEPTH)) ? AW'(tail_sum - SW'(DEPTH)) : AW'(tail_sum);
    assign cap      = (WW'(r_count) > WW'(MAX_RESULTS)) ? CW'(MAX_RESULTS) : r_count;

    assign o_ready = (r_state == S_IDLE);
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_count     = r_count;
        n_rptr      = r_rptr;
        n_left      = r_left;
        n_err       = r_err;
        n_tmp       = r_tmp;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_head;
        o_mem_wdata = r_tmp;
        o_mem_re    = 1'b0;
        o_mem_raddr = r_head;
        o_push      = 1'b0;
        o_res.status = ST_OK;
        o_res.data   = OUT_W'($signed(i_mem_rdata));
        o_res.last   = (r_left == CW'(1));
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_kind)
                        OP_PUSH: begin
                            if (!i_value_ok) begin
                                n_err   = ST_BAD_ARG;
                                n_state = S_EMIT;
                            end else if (r_count == CW'(DEPTH)) begin
                                n_err   = ST_FULL;
                                n_state = S_EMIT;
                            end else begin
                                o_mem_we    = 1'b1;
                                o_mem_wdata = VALUE_BITS'($signed(i_value));
                                if (r_qmode) begin
                                    o_mem_waddr = tail;
                                end else begin
                                    o_mem_waddr = head_dec;
                                    n_head      = head_dec;
                                end
                                n_count = r_count + 1'b1;
                            end
                        end
                        OP_PALL: begin
                            if (r_count != '0) begin
                                o_mem_re = 1'b1;
                                n_rptr   = r_head;
                                n_left   = cap;
                                n_state  = S_DATA;
                            end
                        end
                        OP_PINT: begin
                            if (r_count == '0) begin
                                n_err   = ST_PINT_EMPTY;
                                n_state = S_EMIT;
                            end else begin
                                o_mem_re = 1'b1;
                                n_rptr   = r_head;
                                n_left   = CW'(1);
                                n_state  = S_DATA;
                            end
                        end
                        OP_POP: begin
                            if (r_count == '0) begin
                                n_err   = ST_POP_EMPTY;
                                n_state = S_EMIT;
                            end else begin
                                n_head  = head_inc;
                                n_count = r_count - 1'b1;
                            end
                        end
                        OP_SWAP: begin
                            if (r_count < CW'(2)) begin
                                n_err   = ST_SWAP_SHORT;
                                n_state = S_EMIT;
                            end else begin
                                o_mem_re = 1'b1;
                                n_state  = S_SW1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_DATA: begin
                if (i_space) begin
                    o_push = 1'b1;
                    if (r_left == CW'(1)) begin
                        n_state = S_IDLE;
                    end else begin
                        n_left      = r_left - 1'b1;
                        n_rptr      = rptr_inc;
                        o_mem_re    = 1'b1;
                        o_mem_raddr = rptr_inc;
                    end
                end
            end
            S_EMIT: begin
                o_res.status = r_err;
                o_res.data   = '0;
                o_res.last   = 1'b1;
                if (i_space) begin
                    o_push  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_SW1: begin
                n_tmp       = i_mem_rdata;
                o_mem_re    = 1'b1;
                o_mem_raddr = head_inc;
                n_state     = S_SW2;
            end
            S_SW2: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_head;
                o_mem_wdata = i_mem_rdata;
                n_state     = S_SW3;
            end
            S_SW3: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = head_inc;
                o_mem_wdata = r_tmp;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_count <= '0;
            r_qmode <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
            if (i_cfg_wr_en) begin
                r_qmode <= i_cfg_wr_data;
            end
        end
        r_rptr <= n_rptr;
        r_left <= n_left;
        r_err  <= n_err;
        r_tmp  <= n_tmp;
    end

endmodule

// ===== rtl/core/stack_queue_opcode_engine.sv =====
// Top level: stack/queue opcode engine over a ring of DEPTH entries.
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid / s_axis_tready  tuser kind, tdata {value_ok, value}
//  m_axis    out  m_axis_tvalid / m_axis_tready  tuser status, tdata data_out, tlast
//  cfg       in   i_cfg_wr_en                    i_cfg_wr_data queue_mode
//
// Push, pop and unused opcodes finish on acceptance; errors go through S_EMIT, pint
// through S_DATA; swap's S_SW1-S_SW3 do two reads and two writes on the single write port.
// Print all emits one element per cycle while the output has space, capped at 32.
// Synchronous active-low reset clears head, count, mode and the sequencer.
// Output back-pressure holds the sequencer; one result waits in the output register.
`timescale 1ns / 1ps
module stack_queue_opcode_engine import sqoe_pkg::*; #(
    parameter int DEPTH      = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic              i_cfg_wr_data,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [39:0]       s_axis_tdata,  // [31:0] value, [32] value_ok, rest zero
    input  logic [KIND_W-1:0] s_axis_tuser,  // [2:0] kind
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [31:0]       m_axis_tdata,  // [31:0] data_out
    output logic [STAT_W-1:0] m_axis_tuser,  // [2:0] status
    output logic              m_axis_tlast
);

    localparam int AW = $clog2(DEPTH);

    logic                  mem_we, mem_re;
    logic [AW-1:0]         mem_waddr, mem_raddr;
    logic [VALUE_BITS-1:0] mem_wdata, mem_rdata;
    logic                  space, push;
    t_res                  res, out_res;

    sqoe_ctrl #(
        .DEPTH      (DEPTH),
        .VALUE_BITS (VALUE_BITS)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_kind        (s_axis_tuser),
        .i_value       (s_axis_tdata[31:0]),
        .i_value_ok    (s_axis_tdata[32]),
        .o_mem_we      (mem_we),
        .o_mem_waddr   (mem_waddr),
        .o_mem_wdata   (mem_wdata),
        .o_mem_re      (mem_re),
        .o_mem_raddr   (mem_raddr),
        .i_mem_rdata   (mem_rdata),
        .i_space       (space),
        .o_push        (push),
        .o_res         (res)
    );

    sqoe_ram #(
        .DEPTH (DEPTH),
        .WIDTH (VALUE_BITS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    sqoe_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_res   (res),
        .o_space (space),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_res   (out_res)
    );

    assign m_axis_tdata = out_res.data;
    assign m_axis_tuser = out_res.status;
    assign m_axis_tlast = out_res.last;

endmodule
